[src/cpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 64;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned OCC_W          = 7;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_ACCESSED = 2'd1,
    MARK_UNUSED   = 2'd2
  } mark_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_VICTIM = 2'd0,
    REQ_PIN    = 2'd1,
    REQ_UNPIN  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SWEEP,
    ST_PICK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd_idx;
    logic upd;
    logic sweep;
    logic pick;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[src/cpr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl
  import cpr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [REQ_W-1:0] req_type_i,
  input  wire stat_t            stat_i,
  output logic                  in_ready_o,
  output cmd_t                  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_e'(req_type_i))
            REQ_VICTIM: state_d = ST_SWEEP;
            REQ_PIN:    state_d = ST_READ;
            REQ_UNPIN:  state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_SWEEP: begin
        if (stat_i.sweep_last) state_d = ST_PICK;
      end
      ST_PICK:   state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_READ:   cmd_o.rd_idx = 1'b1;
      ST_UPDATE: cmd_o.upd = 1'b1;
      ST_SWEEP:  cmd_o.sweep = 1'b1;
      ST_PICK:   cmd_o.pick = 1'b1;
      ST_DONE:   cmd_o.out_load = stat_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/cpr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpr_datapath
  import cpr_pkg::*;
#(
  parameter int unsigned NumFrames = NUM_FRAMES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [REQ_W-1:0] req_type_i,
  input  wire logic [IDX_W-1:0] frame_index_i,
  input  wire logic             out_ready_i,
  output stat_t                 stat_o,
  output logic                  out_valid_o,
  output logic                  found_o,
  output logic [IDX_W-1:0]      victim_frame_o,
  output logic [OCC_W-1:0]      occupied_o
);

  localparam int unsigned FW = $clog2(NumFrames);
  localparam int unsigned CW = $clog2(NumFrames + 1);
  localparam int unsigned NumIdx = 1 << IDX_W;

  function automatic logic [FW-1:0] idx_wrap(input logic [IDX_W-1:0] v);
    logic [FW-1:0] r;
    int unsigned   k;
    r = '0;
    for (k = 0; k < NumIdx; k++) begin
      if (v == IDX_W'(k)) r = FW'(k % NumFrames);
    end
    return r;
  endfunction

  mark_e mem [NumFrames];
  mark_e rd_q;

  logic          mem_we;
  logic [FW-1:0] mem_wa;
  mark_e         mem_wd;
  logic          mem_re;
  logic [FW-1:0] mem_ra;

  req_e          req_q;
  logic [FW-1:0] idx_q;
  logic [FW-1:0] hand_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] occ_q;
  logic [FW-1:0] sweep_addr_q;
  logic [FW-1:0] proc_addr_q;
  logic          pv_q;
  logic          have_un_q, have_acc_q;
  logic [FW-1:0] un_q, acc_q;
  logic          found_q;
  logic [FW-1:0] victim_q;
  logic          out_valid_q;
  logic          out_found_q;
  logic [FW-1:0] out_victim_q;
  logic [CW-1:0] out_occ_q;

  logic          sweep_issue;
  logic          sweep_last;
  logic          have_any;
  logic [FW-1:0] pick_sel;

  assign sweep_last  = (cnt_q == CW'(NumFrames));
  assign sweep_issue = cmd_i.sweep && !sweep_last;
  assign have_any    = have_un_q || have_acc_q;
  assign pick_sel    = have_un_q ? un_q : acc_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_addr_q;
    mem_wd = MARK_EMPTY;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
      mem_wa = cnt_q[FW-1:0];
    end else if (cmd_i.upd) begin
      mem_we = (req_q == REQ_PIN) || (req_q == REQ_UNPIN);
      mem_wa = idx_q;
      mem_wd = (req_q == REQ_UNPIN) ? MARK_ACCESSED : MARK_EMPTY;
    end else if (cmd_i.sweep) begin
      mem_we = pv_q && (rd_q == MARK_ACCESSED);
      mem_wa = proc_addr_q;
      mem_wd = MARK_UNUSED;
    end else if (cmd_i.pick) begin
      mem_we = have_any;
      mem_wa = pick_sel;
    end
  end

  assign mem_re = cmd_i.rd_idx || sweep_issue;
  assign mem_ra = cmd_i.rd_idx ? idx_q : sweep_addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hand_q      <= '0;
      occ_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.load) begin
        cnt_q <= '0;
        pv_q  <= 1'b0;
      end else if (cmd_i.sweep) begin
        pv_q <= sweep_issue;
        if (sweep_issue) cnt_q <= cnt_q + CW'(1);
      end

      if (cmd_i.upd) begin
        if (req_q == REQ_PIN && rd_q != MARK_EMPTY) occ_q <= occ_q - CW'(1);
        if (req_q == REQ_UNPIN && rd_q == MARK_EMPTY) occ_q <= occ_q + CW'(1);
      end
      if (cmd_i.pick && have_any) begin
        occ_q  <= occ_q - CW'(1);
        hand_q <= pick_sel;
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_un_q  <= 1'b0;
      have_acc_q <= 1'b0;
      found_q    <= 1'b0;
      req_q      <= REQ_NOP;
    end else begin
      if (cmd_i.load) begin
        have_un_q  <= 1'b0;
        have_acc_q <= 1'b0;
        found_q    <= 1'b0;
        req_q      <= req_e'(req_type_i);
      end else if (cmd_i.sweep && pv_q) begin
        if (rd_q == MARK_UNUSED && !have_un_q) have_un_q <= 1'b1;
        if (rd_q == MARK_ACCESSED && !have_acc_q) have_acc_q <= 1'b1;
      end else if (cmd_i.pick) begin
        found_q <= have_any;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q        <= idx_wrap(frame_index_i);
      sweep_addr_q <= hand_q;
      victim_q     <= '0;
    end
    if (sweep_issue) begin
      proc_addr_q  <= sweep_addr_q;
      sweep_addr_q <= (sweep_addr_q == FW'(NumFrames - 1)) ? '0 : sweep_addr_q + FW'(1);
    end
    if (cmd_i.sweep && pv_q) begin
      if (rd_q == MARK_UNUSED && !have_un_q) un_q <= proc_addr_q;
      if (rd_q == MARK_ACCESSED && !have_acc_q) acc_q <= proc_addr_q;
    end
    if (cmd_i.pick && have_any) victim_q <= pick_sel;
    if (cmd_i.out_load) begin
      out_found_q  <= found_q;
      out_victim_q <= victim_q;
      out_occ_q    <= occ_q;
    end
  end

  assign stat_o.clr_last   = (cnt_q == CW'(NumFrames - 1));
  assign stat_o.sweep_last = sweep_last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign victim_frame_o = IDX_W'(out_victim_q);
  assign occupied_o     = OCC_W'(out_occ_q);

endmodule

`default_nettype wire

[src/clock_page_replacer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Clock (second-chance) page replacer over NUM_FRAMES frame marks kept in a
// simple dual-port memory (one write, one registered read per cycle). After
// reset the block clears all marks with in_ready_o low. For pin and unpin
// the block reads the old mark, writes the new mark and loads the result.
// For a victim request the block sweeps all marks from the hand on, one mark
// per cycle from the memory. It records the first unused frame and the first
// accessed frame. Then the block retires the chosen frame and loads the
// result. An unknown request type goes straight to loading its result. The
// next item can be accepted in the cycle after the result is loaded. The
// result load waits while an earlier result is still held in the output
// register. One item is in work at a time; the output register lets the
// next item be accepted while a result waits.

module clock_page_replacer
  import cpr_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [REQ_W-1:0] req_type_i,
  input  wire logic [IDX_W-1:0] frame_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      victim_frame_o,
  output logic [OCC_W-1:0]      occupied_o
);

  cmd_t  cmd;
  stat_t stat;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  cpr_datapath #(
    .NumFrames (NUM_FRAMES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .frame_index_i  (frame_index_i),
    .out_ready_i    (out_ready_i),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .victim_frame_o (victim_frame_o),
    .occupied_o     (occupied_o)
  );

endmodule

`default_nettype wire
